>>> sv/imwc_pkg.sv
// Package: shared codes, constants and item types of the window correlation core.
`timescale 1ns / 1ps
package imwc_pkg;

  // Command codes of an input item
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // Fixed field widths
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned ROW_W   = 10;
  localparam int unsigned IDX_W   = 7;
  localparam int unsigned CFG_A_W = 3;
  localparam int unsigned CFG_D_W = 11;

  // Result queue depth
  localparam int unsigned FIFO_DEPTH = 8;

  // Configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_ROI_FIRST_COL = 3'd1,
    REG_ROI_END_COL   = 3'd2,
    REG_ROI_FIRST_ROW = 3'd3,
    REG_ROI_END_ROW   = 3'd4,
    REG_KERNEL_WIDTH  = 3'd5,
    REG_KERNEL_HEIGHT = 3'd6
  } reg_e;

  // Coefficient remap sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CLEAR = 3'b010,
    ST_FILL  = 3'b100
  } sweep_e;

  // Per-pixel bookkeeping that travels along the pipeline
  typedef struct packed {
    logic             emit;
    logic             last;
    logic             err;
    logic [POS_W-1:0] col;
    logic [ROW_W-1:0] row;
  } meta_t;

  // One result item
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [POS_W-1:0]        col;
    logic [ROW_W-1:0]        row;
    logic                    last;
    logic                    err;
  } res_t;

endpackage

>>> sv/imwc_if.sv
// Interfaces: pixel/coefficient input channel, result channel, register write channel.
`timescale 1ns / 1ps
interface imwc_in_if #(
  parameter int unsigned PIXEL_BITS = 16,
  parameter int unsigned COEF_BITS  = 16
);
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [6:0]                   coef_index;
  logic signed [COEF_BITS-1:0]  coef_value;
  logic signed [PIXEL_BITS-1:0] pixel_value;
  logic                         frame_start;

  modport source (output valid, command, coef_index, coef_value, pixel_value, frame_start,
                  input ready);
  modport sink   (input valid, command, coef_index, coef_value, pixel_value, frame_start,
                  output ready);
endinterface

interface imwc_out_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] window_sum;
  logic [9:0]         out_col;
  logic [9:0]         out_row;
  logic               is_last;
  logic               margin_error;

  modport source (output valid, window_sum, out_col, out_row, is_last, margin_error,
                  input ready);
  modport sink   (input valid, window_sum, out_col, out_row, is_last, margin_error,
                  output ready);
endinterface

interface imwc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [10:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/image_2d_window_correlation_core.sv
// Top level: line-buffer 2D window correlation with pipelined multiply and add tree.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+------------------------------------------------
//  in_if    | in  | valid/ready  | command, coef_index, coef_value, pixel_value,
//           |     |              | frame_start
//  out_if   | out | valid/ready  | window_sum, out_col, out_row, is_last, margin_error
//  cfg_if   | in  | valid/ready  | index, data (register write, always ready)
//
// One item per cycle while in_if.ready is high; results are offered through an 8-entry queue.
// The line buffer is one memory word per column, read and written back once per pixel.
// After a coefficient load or a kernel size write the first pixel waits for the pipeline
// to empty, then while the taps are cleared and the coefficients are copied.
// rst_ni clears control state only; line buffer and coefficients are undefined until written.
// A stalled output fills the queue; input is held off by credit, the pipeline never stalls.
`timescale 1ns / 1ps
module image_2d_window_correlation_core
  import imwc_pkg::*;
#(
  parameter int unsigned MAX_KERNEL = 9,
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned PIXEL_BITS = 16,
  parameter int unsigned COEF_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  imwc_in_if.sink     in_if,
  imwc_out_if.source  out_if,
  imwc_cfg_if.sink    cfg_if
);

  localparam int unsigned MK    = MAX_KERNEL;
  localparam int unsigned PB    = PIXEL_BITS;
  localparam int unsigned CB    = COEF_BITS;
  localparam int unsigned LINES = (MK > 1) ? MK - 1 : 1;
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned XW    = ((CW + 1 > CFG_D_W) ? CW + 1 : CFG_D_W) + 2;
  localparam int unsigned KAW   = (MK > 1) ? $clog2(MK * MK) : 1;
  localparam int unsigned KIW   = (MK > 1) ? $clog2(MK) : 1;
  localparam int unsigned PW    = PB + CB;
  localparam int unsigned RSW   = PW + 4;
  localparam int unsigned ACCW  = RSW + 4;
  localparam int unsigned FAW   = $clog2(FIFO_DEPTH);
  localparam int unsigned FCW   = $clog2(FIFO_DEPTH + 1) + 1;

  typedef logic [LINES-1:0][PB-1:0] line_t;

  // ---------------- configuration registers ----------------
  logic [10:0] image_width_q, roi_end_col_q, roi_end_row_q;
  logic [9:0]  roi_first_col_q, roi_first_row_q;
  logic [3:0]  kernel_width_q, kernel_height_q;
  logic        cfg_fire, kern_cfg_wr;

  assign cfg_if.ready = 1'b1;
  assign cfg_fire     = cfg_if.valid && cfg_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q   <= 11'd1024;
      roi_first_col_q <= '0;
      roi_end_col_q   <= 11'd1024;
      roi_first_row_q <= '0;
      roi_end_row_q   <= 11'd1024;
      kernel_width_q  <= 4'd1;
      kernel_height_q <= 4'd1;
    end else if (cfg_fire) begin
      unique case (reg_e'(cfg_if.index))
        REG_IMAGE_WIDTH:   image_width_q   <= cfg_if.data;
        REG_ROI_FIRST_COL: roi_first_col_q <= cfg_if.data[9:0];
        REG_ROI_END_COL:   roi_end_col_q   <= cfg_if.data;
        REG_ROI_FIRST_ROW: roi_first_row_q <= cfg_if.data[9:0];
        REG_ROI_END_ROW:   roi_end_row_q   <= cfg_if.data;
        REG_KERNEL_WIDTH:  kernel_width_q  <= cfg_if.data[3:0];
        REG_KERNEL_HEIGHT: kernel_height_q <= cfg_if.data[3:0];
        default: ;
      endcase
    end
  end

  assign kern_cfg_wr = cfg_fire && ((reg_e'(cfg_if.index) == REG_KERNEL_WIDTH) ||
                                    (reg_e'(cfg_if.index) == REG_KERNEL_HEIGHT));

  // Clamped sizes and margins
  logic [3:0]          kw_eff, kh_eff, kwm1, khm1;
  logic signed [XW-1:0] w_eff, left_s, right_s, above_s, below_s;
  logic signed [XW-1:0] fc_s, ec_s, fr_s, er_s, xlast_s, xlim_s;
  logic                 err_cfg;

  always_comb begin
    kw_eff = (kernel_width_q == '0) ? 4'd1 :
             (kernel_width_q > 4'(MK)) ? 4'(MK) : kernel_width_q;
    kh_eff = (kernel_height_q == '0) ? 4'd1 :
             (kernel_height_q > 4'(MK)) ? 4'(MK) : kernel_height_q;
    kwm1   = kw_eff - 4'd1;
    khm1   = kh_eff - 4'd1;
    w_eff  = (image_width_q == '0) ? XW'(1) :
             (XW'(image_width_q) > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(image_width_q);
    left_s  = XW'(kw_eff >> 1);
    right_s = XW'(kw_eff) - left_s - XW'(1);
    above_s = XW'(kh_eff >> 1);
    below_s = XW'(kh_eff) - above_s - XW'(1);
    fc_s = XW'(roi_first_col_q);
    ec_s = XW'(roi_end_col_q);
    fr_s = XW'(roi_first_row_q);
    er_s = XW'(roi_end_row_q);
    err_cfg = !((fr_s >= above_s) && (fc_s >= left_s) && ((w_eff - ec_s) >= right_s));
    xlim_s  = w_eff - right_s;
    xlast_s = ((xlim_s < ec_s) ? xlim_s : ec_s) - XW'(1);
  end

  // ---------------- input acceptance ----------------
  logic   in_fire, pix_fire, load_fire, credit_ok, pipe_empty, sweep_start;
  logic   dirty_q, dirty_d;
  sweep_e st_q, st_d;
  logic [FCW-1:0] fifo_cnt_q, inflight;

  // pipeline stage valid and meta
  logic  s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q;
  meta_t s1_meta_q, s2_meta_q, s3_meta_q, s4_meta_q, s5_meta_q;

  assign inflight  = FCW'($countones({s1_vld_q & s1_meta_q.emit, s2_vld_q & s2_meta_q.emit,
                                      s3_vld_q & s3_meta_q.emit, s4_vld_q & s4_meta_q.emit,
                                      s5_vld_q & s5_meta_q.emit}));
  assign credit_ok  = (fifo_cnt_q + inflight) < FCW'(FIFO_DEPTH);
  assign pipe_empty = !(s1_vld_q || s2_vld_q || s3_vld_q || s4_vld_q || s5_vld_q);
  assign in_if.ready = (st_q == ST_IDLE) && credit_ok &&
                       !(dirty_q && (in_if.command == CMD_PIXEL));
  assign in_fire   = in_if.valid && in_if.ready;
  assign pix_fire  = in_fire && (in_if.command == CMD_PIXEL);
  assign load_fire = in_fire && (in_if.command == CMD_LOAD);
  assign sweep_start = (st_q == ST_IDLE) && dirty_q && pipe_empty && in_if.valid &&
                       (in_if.command == CMD_PIXEL);

  // ---------------- coefficient memory and tap registers ----------------
  logic signed [CB-1:0] kmem [MK*MK];
  logic signed [CB-1:0] kr_q;
  logic signed [CB-1:0] coef_q [MK][MK];
  logic [KAW-1:0] j_q, j_d;
  logic [3:0]     kx_q, kx_d, ky_q, ky_d, pkx_q, pky_q;
  logic           pend_q, pend_d, sweep_done;
  logic [3:0]     tap_dy, tap_dx;

  always_ff @(posedge clk_i) begin
    if (load_fire && (int'(in_if.coef_index) < MK * MK)) begin
      kmem[KAW'(in_if.coef_index)] <= CB'(in_if.coef_value);
    end
    kr_q <= kmem[j_q];
  end

  // Sequencer: clear taps, then copy row-major coefficients to flipped tap positions
  always_comb begin
    st_d       = st_q;
    kx_d       = kx_q;
    ky_d       = ky_q;
    j_d        = j_q;
    pend_d     = 1'b0;
    sweep_done = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (sweep_start) st_d = ST_CLEAR;
      end
      ST_CLEAR: begin
        kx_d = '0;
        ky_d = '0;
        j_d  = '0;
        st_d = ST_FILL;
      end
      ST_FILL: begin
        pend_d = 1'b1;
        j_d    = j_q + KAW'(1);
        if (kx_q == kwm1) begin
          kx_d = '0;
          if (ky_q == khm1) begin
            sweep_done = 1'b1;
            st_d       = ST_IDLE;
          end else begin
            ky_d = ky_q + 4'd1;
          end
        end else begin
          kx_d = kx_q + 4'd1;
        end
      end
      default: st_d = ST_IDLE;
    endcase
    dirty_d = (load_fire || kern_cfg_wr) ? 1'b1 : (sweep_done ? 1'b0 : dirty_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      dirty_q <= 1'b1;
      pend_q  <= 1'b0;
      kx_q    <= '0;
      ky_q    <= '0;
      j_q     <= '0;
    end else begin
      st_q    <= st_d;
      dirty_q <= dirty_d;
      pend_q  <= pend_d;
      kx_q    <= kx_d;
      ky_q    <= ky_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pkx_q <= kx_q;
    pky_q <= ky_q;
  end

  assign tap_dy = khm1 - pky_q;
  assign tap_dx = kwm1 - pkx_q;

  always_ff @(posedge clk_i) begin
    if (st_q == ST_CLEAR) begin
      for (int dy = 0; dy < MK; dy++) begin
        for (int dx = 0; dx < MK; dx++) begin
          coef_q[dy][dx] <= '0;
        end
      end
    end else if (pend_q) begin
      coef_q[KIW'(tap_dy)][KIW'(tap_dx)] <= kr_q;
    end
  end

  // ---------------- stage 0: position counters and result bookkeeping ----------------
  logic [CW-1:0]    col_q, col_d, c0, c_s;
  logic [ROW_W-1:0] row_q, row_d, r0, r_s;
  logic signed [XW-1:0] c_n, x_s, y_s;
  meta_t            meta_s0;

  always_comb begin
    c0 = in_if.frame_start ? '0 : col_q;
    r0 = in_if.frame_start ? '0 : row_q;
    if (XW'(c0) >= w_eff) begin
      c_s = '0;
      r_s = r0 + ROW_W'(1);
    end else begin
      c_s = c0;
      r_s = r0;
    end
    c_n = XW'(c_s) + XW'(1);
    if (c_n >= w_eff) begin
      col_d = '0;
      row_d = r_s + ROW_W'(1);
    end else begin
      col_d = CW'(c_n);
      row_d = r_s;
    end
    x_s = XW'(c_s) - right_s;
    y_s = XW'(r_s) - below_s;
    meta_s0.emit = (x_s >= 0) && (y_s >= 0) && (x_s >= fc_s) && (x_s < ec_s) &&
                   (y_s >= fr_s) && (y_s < er_s);
    meta_s0.last = (y_s == er_s - XW'(1)) && (x_s == xlast_s);
    meta_s0.err  = err_cfg;
    meta_s0.col  = x_s[POS_W-1:0];
    meta_s0.row  = y_s[ROW_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (pix_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------- line buffer memory, one word per column ----------------
  line_t row_mem [MAX_WIDTH];
  line_t row_rd_q, row_old, row_wr, fwd_q;
  logic signed [PB-1:0] s1_pix_q;
  logic [CW-1:0]        s1_col_q, s2_col_q;
  logic [ROW_W-1:0]     s1_row_q, s2_row_q;
  logic                 s1_fwd_q;

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) row_mem[s1_col_q] <= row_wr;
    if (pix_fire) row_rd_q <= row_mem[c_s];
  end

  // Same column written back in the cycle of the read: take the write data instead
  assign row_old = s1_fwd_q ? fwd_q : row_rd_q;

  logic signed [PB-1:0] colv [MK];
  assign colv[0]   = s1_pix_q;
  assign row_wr[0] = s1_pix_q;
  for (genvar i = 1; i < LINES; i++) begin : g_shift
    assign row_wr[i] = row_old[i-1];
  end
  for (genvar i = 1; i < MK; i++) begin : g_colv
    assign colv[i] = row_old[i-1];
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      s1_pix_q  <= PB'(in_if.pixel_value);
      s1_col_q  <= c_s;
      s1_row_q  <= r_s;
      s1_meta_q <= meta_s0;
      s1_fwd_q  <= s1_vld_q && (s1_col_q == c_s);
      fwd_q     <= row_wr;
    end
  end

  // ---------------- window shift register ----------------
  logic signed [PB-1:0] win_q [MK][MK];

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      for (int i = 0; i < MK; i++) begin
        for (int k = MK - 1; k > 0; k--) begin
          win_q[i][k] <= win_q[i][k-1];
        end
        win_q[i][0] <= colv[i];
      end
    end
  end

  // ---------------- multiply, row sums, total ----------------
  logic signed [PW-1:0]   prod_q [MK][MK];
  logic signed [RSW-1:0]  rs_q [MK];
  logic signed [RSW-1:0]  rs_d [MK];
  logic signed [ACCW-1:0] total_q, total_d;

  always_ff @(posedge clk_i) begin
    for (int dy = 0; dy < MK; dy++) begin
      for (int dx = 0; dx < MK; dx++) begin
        if ((s2_col_q >= CW'(dx)) && (s2_row_q >= ROW_W'(dy))) begin
          prod_q[dy][dx] <= coef_q[dy][dx] * win_q[dy][dx];
        end else begin
          prod_q[dy][dx] <= '0;
        end
      end
    end
  end

  always_comb begin
    for (int dy = 0; dy < MK; dy++) begin
      rs_d[dy] = '0;
      for (int dx = 0; dx < MK; dx++) begin
        rs_d[dy] = rs_d[dy] + RSW'(prod_q[dy][dx]);
      end
    end
    total_d = '0;
    for (int dy = 0; dy < MK; dy++) begin
      total_d = total_d + ACCW'(rs_q[dy]);
    end
  end

  always_ff @(posedge clk_i) begin
    s2_col_q  <= s1_col_q;
    s2_row_q  <= s1_row_q;
    s2_meta_q <= s1_meta_q;
    s3_meta_q <= s2_meta_q;
    s4_meta_q <= s3_meta_q;
    s5_meta_q <= s4_meta_q;
    rs_q      <= rs_d;
    total_q   <= total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= pix_fire;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  // ---------------- result queue ----------------
  res_t                fifo_q [FIFO_DEPTH];
  res_t                push_item;
  logic [FAW-1:0]      wp_q, rp_q;
  logic                push, pop;
  logic signed [63:0]  total_ext;

  assign total_ext      = 64'(total_q);
  assign push_item.sum  = total_ext[SUM_W-1:0];
  assign push_item.col  = s5_meta_q.col;
  assign push_item.row  = s5_meta_q.row;
  assign push_item.last = s5_meta_q.last;
  assign push_item.err  = s5_meta_q.err;
  assign push = s5_vld_q && s5_meta_q.emit;
  assign pop  = out_if.valid && out_if.ready;

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= push_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      rp_q       <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + FAW'(1);
      if (pop)  rp_q <= rp_q + FAW'(1);
      fifo_cnt_q <= fifo_cnt_q + FCW'(push) - FCW'(pop);
    end
  end

  assign out_if.valid        = (fifo_cnt_q != '0);
  assign out_if.window_sum   = fifo_q[rp_q].sum;
  assign out_if.out_col      = fifo_q[rp_q].col;
  assign out_if.out_row      = fifo_q[rp_q].row;
  assign out_if.is_last      = fifo_q[rp_q].last;
  assign out_if.margin_error = fifo_q[rp_q].err;

`ifndef NO_ASSERTIONS
  // Credit scheme keeps queue plus in-flight results within the queue depth
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_cnt_q + inflight) <= FCW'(FIFO_DEPTH))
    else $error("result queue credit exceeded");

  // No pixel enters while tap registers are stale or being rebuilt
  a_no_pix_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_fire |-> (st_q == ST_IDLE) && !dirty_q)
    else $error("pixel accepted with stale coefficients");

  // Sweep only starts with an empty pipeline
  a_sweep_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CLEAR) |-> $past(pipe_empty))
    else $error("coefficient sweep started with items in flight");

  // Forwarding only follows a write of the same column in the previous cycle
  a_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && s1_fwd_q) |-> ($past(s1_vld_q) && ($past(s1_col_q) == s1_col_q)))
    else $error("line buffer forward without matching write");

  // Never pop an empty queue
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (fifo_cnt_q != '0))
    else $error("result queue underflow");
`endif

endmodule

>>> sim/imwc_tb_pkg.sv
// Testbench package: the behavioral predictor of the window correlation core.
`timescale 1ns / 1ps
package imwc_tb_pkg;
  import imwc_pkg::*;

  localparam int unsigned KMAX  = 9;
  localparam int unsigned WMAX  = 1024;
  localparam int unsigned LINES = KMAX - 1;

  // Register file copy, reset values
  logic [10:0] img_width = 11'd1024;
  logic [9:0]  roi_fc    = 10'd0;
  logic [10:0] roi_ec    = 11'd1024;
  logic [9:0]  roi_fr    = 10'd0;
  logic [10:0] roi_er    = 11'd1024;
  logic [3:0]  krn_w     = 4'd1;
  logic [3:0]  krn_h     = 4'd1;

  // Line buffers, window taps, coefficients, raster position
  logic signed [15:0] line_mem [LINES][WMAX];
  logic signed [15:0] win_taps [KMAX][KMAX];
  logic signed [15:0] coefs [KMAX*KMAX];
  int unsigned        cur_col = 0;
  int unsigned        cur_row = 0;

  function automatic int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void reg_write(logic [2:0] idx, logic [10:0] data);
    case (idx)
      REG_IMAGE_WIDTH:   img_width = data;
      REG_ROI_FIRST_COL: roi_fc = data[9:0];
      REG_ROI_END_COL:   roi_ec = data;
      REG_ROI_FIRST_ROW: roi_fr = data[9:0];
      REG_ROI_END_ROW:   roi_er = data;
      REG_KERNEL_WIDTH:  krn_w = data[3:0];
      REG_KERNEL_HEIGHT: krn_h = data[3:0];
      default: ;
    endcase
  endfunction

  function automatic void coef_load(logic [6:0] idx, logic signed [15:0] val);
    if (idx < KMAX*KMAX) coefs[idx] = val;
  endfunction

  // Advance the window by one pixel; returns 1 and fills res when a result is due
  function automatic bit pixel_step(logic signed [15:0] pix, logic fs, output res_t res);
    int w, kw, kh, left, right, above, below, c, r, x, y, xl, dx, dy;
    logic signed [15:0] colv [KMAX];
    longint acc;
    res = '0;
    w = clip(img_width, 1, WMAX);
    kw = clip(krn_w, 1, KMAX);
    kh = clip(krn_h, 1, KMAX);
    left = kw / 2; right = kw - left - 1;
    above = kh / 2; below = kh - above - 1;
    if (fs) begin
      cur_col = 0; cur_row = 0;
    end
    if (cur_col >= w) begin
      cur_col = 0; cur_row = (cur_row + 1) & 10'h3ff;
    end
    c = cur_col; r = cur_row;
    // new column: fresh pixel on top of the stored rows
    colv[0] = pix;
    for (int i = 1; i < KMAX; i++) colv[i] = line_mem[i-1][c];
    for (int i = LINES - 1; i > 0; i--) line_mem[i][c] = line_mem[i-1][c];
    line_mem[0][c] = pix;
    for (int i = 0; i < KMAX; i++) begin
      for (int k = KMAX - 1; k > 0; k--) win_taps[i][k] = win_taps[i][k-1];
      win_taps[i][0] = colv[i];
    end
    cur_col = c + 1;
    if (cur_col >= w) begin
      cur_col = 0; cur_row = (cur_row + 1) & 10'h3ff;
    end
    x = c - right; y = r - below;
    if (x < 0 || y < 0) return 0;
    if (x < int'(roi_fc) || x >= int'(roi_ec)) return 0;
    if (y < int'(roi_fr) || y >= int'(roi_er)) return 0;
    acc = 0;
    for (int ky = 0; ky < kh; ky++) begin
      dy = kh - 1 - ky;
      if (dy <= r)
        for (int kx = 0; kx < kw; kx++) begin
          dx = kw - 1 - kx;
          if (dx <= c) acc += longint'(coefs[ky*kw+kx]) * longint'(win_taps[dy][dx]);
        end
    end
    xl = int'(roi_ec);
    if (w - right < xl) xl = w - right;
    xl -= 1;
    res.sum  = acc[39:0];
    res.col  = x[9:0];
    res.row  = y[9:0];
    res.last = (y == int'(roi_er) - 1) && (x == xl);
    res.err  = !(int'(roi_fr) >= above && int'(roi_fc) >= left && w - int'(roi_ec) >= right);
    return 1;
  endfunction

  function automatic void reset_state();
    img_width = 11'd1024; roi_fc = '0; roi_ec = 11'd1024;
    roi_fr = '0; roi_er = 11'd1024; krn_w = 4'd1; krn_h = 4'd1;
    cur_col = 0; cur_row = 0;
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    foreach (win_taps[i, j]) win_taps[i][j] = '0;
    foreach (coefs[i]) coefs[i] = '0;
  endfunction
endpackage

>>> sim/tb_image_2d_window_correlation_core.sv
// Testbench top: directed and random stimulus for the window correlation core.
`timescale 1ns / 1ps
module tb_image_2d_window_correlation_core;
  import imwc_pkg::*;
  import imwc_tb_pkg::*;

  // Register index with no register behind it
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  imwc_in_if  in_bus ();
  imwc_out_if out_bus ();
  imwc_cfg_if cfg_bus ();

  image_2d_window_correlation_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  res_t sum_q [$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   pixels_sent = 0;
  int   loads_sent = 0;
  int   cfg_writes = 0;
  int   hold_cycles = 0;
  int   burst_left = 0;
  int   rx_stall_pct = 0;
  int   rx_phase = 0;

  // Receiver: long hold-off when requested, otherwise a changing stall pattern
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_bus.ready <= 1'b0;
      hold_cycles--;
    end else begin
      rx_phase++;
      if (rx_phase % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: rx_stall_pct = 0;
          1: rx_stall_pct = 20;
          2: rx_stall_pct = 50;
          default: rx_stall_pct = 80;
        endcase
      end
      out_bus.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (sum_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: sum %0d col %0d row %0d", out_bus.window_sum,
                   out_bus.out_col, out_bus.out_row);
      end else begin
        want = sum_q.pop_front();
        if (out_bus.window_sum !== want.sum || out_bus.out_col !== want.col ||
            out_bus.out_row !== want.row || out_bus.is_last !== want.last ||
            out_bus.margin_error !== want.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp sum %0d col %0d row %0d last %0b err %0b / got %0d %0d %0d %0b %0b",
                     want.sum, want.col, want.row, want.last, want.err, out_bus.window_sum,
                     out_bus.out_col, out_bus.out_row, out_bus.is_last, out_bus.margin_error);
        end
      end
    end
  end

  // Send one item, honoring the burst/gap pattern of the sender
  task automatic send_item(logic cmd, logic [6:0] idx, logic signed [15:0] cval,
                           logic signed [15:0] pval, logic fs);
    int gap;
    res_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_bus.valid       <= 1'b1;
    in_bus.command     <= cmd;
    in_bus.coef_index  <= idx;
    in_bus.coef_value  <= cval;
    in_bus.pixel_value <= pval;
    in_bus.frame_start <= fs;
    do @(posedge clk_i); while (!in_bus.ready);
    if (cmd == CMD_LOAD) begin
      coef_load(idx, cval);
      loads_sent++;
    end else begin
      pixels_sent++;
      if (pixel_step(pval, fs, r)) sum_q.push_back(r);
    end
  endtask

  task automatic send_pixel(logic signed [15:0] p, logic fs);
    send_item(CMD_PIXEL, 7'($urandom_range(0, 127)), 16'($urandom), p, fs);
  endtask

  task automatic send_load(logic [6:0] idx, logic signed [15:0] v);
    send_item(CMD_LOAD, idx, v, 16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic stop_sending();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every expected result, then for the coefficient copy and pipeline
  task automatic drain();
    stop_sending();
    while (sum_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [10:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    reg_write(idx, data);
    cfg_writes++;
  endtask

  task automatic set_geometry(int w, int fc, int ec, int fr, int er, int kw, int kh);
    write_reg(REG_IMAGE_WIDTH, 11'(w));
    write_reg(REG_ROI_FIRST_COL, 11'(fc));
    write_reg(REG_ROI_END_COL, 11'(ec));
    write_reg(REG_ROI_FIRST_ROW, 11'(fr));
    write_reg(REG_ROI_END_ROW, 11'(er));
    write_reg(REG_KERNEL_WIDTH, 11'(kw));
    write_reg(REG_KERNEL_HEIGHT, 11'(kh));
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Send a frame of the given size, with optional noise
  task automatic send_frame(int w, int rows, bit noisy);
    for (int i = 0; i < w * rows; i++) begin
      if (noisy && $urandom_range(0, 99) < 3)
        send_load(7'($urandom_range(0, 127)), rand_sample());
      send_pixel(rand_sample(), i == 0 || (noisy && $urandom_range(0, 199) == 0));
    end
  endtask

  // Full kernel load, including extremes and ignored indexes
  task automatic test_kernel_load();
    for (int i = 0; i < 81; i++)
      send_load(7'(i), (i == 0) ? 16'sh8000 : (i == 80) ? 16'sh7fff : rand_sample());
    send_load(7'd81, 16'sh1234);
    send_load(7'd127, 16'sh8000);
    drain();
  endtask

  // Small directed frame with a 3x3 kernel, margins violated on the top, left and right edges
  task automatic test_directed();
    set_geometry(4, 0, 4, 0, 3, 3, 3);
    send_pixel(16'sh7fff, 1'b1);
    send_pixel(16'sh8000, 1'b0);
    send_pixel(16'sh0000, 1'b0);
    send_pixel(16'shffff, 1'b0);
    // ends two pixels into a row
    for (int i = 0; i < 10; i++) send_pixel(i[0] ? 16'sh8000 : 16'sh7fff, 1'b0);
    drain();
    // shrink the row width mid-row without a new frame
    set_geometry(2, 1, 2, 0, 6, 2, 2);
    for (int i = 0; i < 8; i++) send_pixel(rand_sample(), 1'b0);
    drain();
    write_reg(REG_UNUSED, 11'h7ff);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    set_geometry(8, 0, 8, 0, 10, 1, 1);
    hold_cycles = 300;
    burst_left = 100;
    send_frame(8, 10, 1'b0);
    drain();
  endtask

  // Width-one image through the row counter wrap
  task automatic test_row_wrap();
    set_geometry(1, 0, 1024, 0, 1024, 1, 1);
    send_frame(1, 1030, 1'b0);
    drain();
  endtask

  // Clamped width and kernel sizes, ROI against the right edge
  task automatic test_wide_frame();
    set_geometry(2047, 0, 1024, 0, 1, 3, 1);
    send_frame(8, 1, 1'b0);
    drain();
    set_geometry(1024, 1023, 1024, 1023, 1024, 0, 15);
    send_frame(4, 2, 1'b0);
    drain();
  endtask

  // Random geometries and frames
  task automatic test_random();
    int w, we, kw, kh, l, rt, ab, bl, fc, ec, fr, er, rows, start;
    start = pixels_sent + loads_sent;
    while (pixels_sent + loads_sent - start < 150) begin
      case ($urandom_range(0, 9))
        0: w = 0;
        1: w = $urandom_range(25, 40);
        default: w = $urandom_range(1, 16);
      endcase
      kw = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 15 : 0) : $urandom_range(1, 9);
      kh = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 15 : 0) : $urandom_range(1, 9);
      we = clip(w, 1, 1024);
      l = clip(kw, 1, 9) / 2; rt = clip(kw, 1, 9) - l - 1;
      ab = clip(kh, 1, 9) / 2; bl = clip(kh, 1, 9) - ab - 1;
      if ($urandom_range(0, 9) < 7 && we - rt > l) begin
        fc = $urandom_range(l, we - rt - 1);
        ec = $urandom_range(fc + 1, we - rt);
        fr = ab + $urandom_range(0, 2);
      end else begin
        fc = $urandom_range(0, we + 1);
        ec = $urandom_range(0, we + 2);
        fr = $urandom_range(0, 3);
      end
      er = fr + $urandom_range(0, 3);
      rows = er + bl + $urandom_range(0, 1);
      if (rows < 1) rows = 1;
      if (rows * we > 250) rows = 250 / we;
      set_geometry(w, fc, ec, fr, er, kw, kh);
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 10)) send_load(7'($urandom_range(0, 127)), rand_sample());
      send_frame(we, rows, 1'b1);
      drain();
    end
  endtask

  initial begin
    reset_state();
    in_bus.valid = 1'b0;
    in_bus.command = CMD_PIXEL;
    in_bus.coef_index = '0;
    in_bus.coef_value = '0;
    in_bus.pixel_value = '0;
    in_bus.frame_start = 1'b0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_kernel_load();
    test_directed();
    test_backpressure();
    test_row_wrap();
    test_wide_frame();
    test_random();

    drain();
    $display("covered %0d pixels, %0d coefficient loads, %0d register writes",
             pixels_sent, loads_sent, cfg_writes);
    $display("checked %0d window results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && sum_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

>>> filelist.f
sv/imwc_pkg.sv
sv/imwc_if.sv
sv/image_2d_window_correlation_core.sv
sim/imwc_tb_pkg.sv
sim/tb_image_2d_window_correlation_core.sv
